### rtl/core/klirs_pkg.sv
// shared types and codes for the keyed list block
// no dependencies; imported by the sequencer and the top level
package klirs_pkg;

  localparam int KEY_BYTES = 29;
  localparam int KEY_W     = 8 * KEY_BYTES;
  localparam int CLASS_W   = 152;
  localparam int AMT_W     = 32;
  localparam int ENTRY_W   = KEY_W + CLASS_W + AMT_W;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_EMPTY   = 2'd2,
    STAT_MISSING = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_SHIFT,
    ST_RESULT
  } state_t;

  // sequencer to datapath controls
  typedef struct packed {
    logic we;
    logic shift_src;
    logic load_found;
    logic done;
  } ctl_t;

endpackage

### rtl/core/keyed_list_insert_remove_search.sv
// Keyed list with insert, remove and search by name, holding up to CAPACITY
// entries in one ram that a small sequencer walks one entry per cycle through
// its single read port. An item is taken when start is high and busy is low;
// its result shows for exactly one cycle with done high and cannot be held off.
// Insert, no-op and operations on an empty table finish straight from dispatch
// without a scan; a search or remove scans from the first entry until it finds
// a match or passes the last entry, and a remove that matches then moves every
// later entry down one. No clearing pass: only entries below the fill count are
// ever read.
// depends on klirs_pkg, klirs_ram, klirs_seq
module keyed_list_insert_remove_search import klirs_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [63:0] key_word_0,
  input  logic [63:0] key_word_1,
  input  logic [63:0] key_word_2,
  input  logic [39:0] key_word_3,
  input  logic [63:0] class_word_0,
  input  logic [63:0] class_word_1,
  input  logic [23:0] class_word_2,
  input  logic signed [31:0] amount,
  output logic        done,
  output logic [1:0]  status,
  output logic [3:0]  slot,
  output logic [63:0] found_class_0,
  output logic [63:0] found_class_1,
  output logic [23:0] found_class_2,
  output logic signed [31:0] found_amount,
  output logic [4:0]  occupancy
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  // a name ends at its first zero byte; later bytes read as zero
  function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] raw);
    logic [KEY_BYTES-1:0] nz;
    logic [KEY_BYTES-1:0] run;
    logic [2:0]           whole;
    logic [3:0]           pre;
    logic [KEY_W-1:0]     res;
    for (int i = 0; i < KEY_BYTES; i++) begin
      nz[i] = |raw[8*i +: 8];
    end
    run = '0;
    for (int g = 0; g < 4; g++) begin
      for (int j = 0; j < 8; j++) begin
        if (g * 8 + j < KEY_BYTES) begin
          if (j == 0) begin
            run[g*8] = nz[g*8];
          end else begin
            run[g*8+j] = run[g*8+j-1] & nz[g*8+j];
          end
        end
      end
    end
    for (int g = 0; g < 3; g++) begin
      whole[g] = run[g*8+7];
    end
    pre[0] = 1'b1;
    for (int g = 1; g < 4; g++) begin
      pre[g] = pre[g-1] & whole[g-1];
    end
    for (int i = 0; i < KEY_BYTES; i++) begin
      res[8*i +: 8] = (pre[i/8] & run[i]) ? raw[8*i +: 8] : 8'h00;
    end
    return res;
  endfunction

  logic [KEY_W-1:0]   key_reg;
  logic [CLASS_W-1:0] class_reg;
  logic [AMT_W-1:0]   amount_reg;
  logic [CLASS_W-1:0] found_class;
  logic [AMT_W-1:0]   found_amt;
  logic               accept;
  logic               hit;
  ctl_t               ctl;
  logic [IW-1:0]      raddr, waddr, res_slot;
  logic [1:0]         res_status;
  logic [CW-1:0]      count;
  logic [ENTRY_W-1:0] rd_data, wr_data;
  logic [IW+3:0]      slot_ext;
  logic [CW+4:0]      occ_ext;

  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (accept) begin
      key_reg    <= norm_key({key_word_3, key_word_2, key_word_1, key_word_0});
      class_reg  <= {class_word_2, class_word_1, class_word_0};
      amount_reg <= amount;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      found_class <= '0;
      found_amt   <= '0;
    end else if (ctl.load_found) begin
      found_class <= rd_data[KEY_W +: CLASS_W];
      found_amt   <= rd_data[KEY_W + CLASS_W +: AMT_W];
    end
  end

  // the one comparator, reused on every entry read back
  assign hit = (rd_data[KEY_W-1:0] == key_reg);

  assign wr_data = ctl.shift_src ? rd_data : {amount_reg, class_reg, key_reg};

  klirs_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ctl.we),
    .waddr(waddr),
    .wdata(wr_data),
    .raddr(raddr),
    .rdata(rd_data)
  );

  klirs_seq #(
    .CAPACITY(CAPACITY)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .kind      (kind),
    .hit       (hit),
    .busy      (busy),
    .ctl       (ctl),
    .raddr     (raddr),
    .waddr     (waddr),
    .res_status(res_status),
    .res_slot  (res_slot),
    .count     (count)
  );

  assign slot_ext = {4'b0, res_slot};
  assign occ_ext  = {5'b0, count};

  assign done          = ctl.done;
  assign status        = res_status;
  assign slot          = slot_ext[3:0];
  assign occupancy     = occ_ext[4:0];
  assign found_class_0 = found_class[63:0];
  assign found_class_1 = found_class[127:64];
  assign found_class_2 = found_class[151:128];
  assign found_amount  = found_amt;

endmodule

### rtl/core/klirs_ram.sv
// generic simple dual port ram: one write port, one read port with registered data
// no dependencies
module klirs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/klirs_seq.sv
// sequencer for the keyed list: dispatch, linear scan, shift-down on remove
// depends on klirs_pkg; drives the ram ports and the result status
module klirs_seq import klirs_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          start,
  input  logic [1:0]                                    kind,
  input  logic                                          hit,
  output logic                                          busy,
  output ctl_t                                          ctl,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] raddr,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] waddr,
  output logic [1:0]                                    res_status,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] res_slot,
  output logic [$clog2(CAPACITY + 1)-1:0]               count
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  state_t        state, state_next;
  op_t           op, op_next;
  logic [CW-1:0] count_next;
  logic [CW-1:0] issue_idx, issue_next;
  logic          rv, rv_next;
  logic [IW-1:0] rd_idx, rd_idx_next;
  status_t       status_r, status_next;
  logic [IW-1:0] slot_r, slot_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rv        <= 1'b0;
      op        <= OP_NONE;
      issue_idx <= '0;
      rd_idx    <= '0;
      status_r  <= STAT_OK;
      slot_r    <= '0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rv        <= rv_next;
      op        <= op_next;
      issue_idx <= issue_next;
      rd_idx    <= rd_idx_next;
      status_r  <= status_next;
      slot_r    <= slot_next;
    end
  end

  always_comb begin
    state_next  = state;
    op_next     = op;
    count_next  = count;
    issue_next  = issue_idx;
    rv_next     = 1'b0;
    rd_idx_next = rd_idx;
    status_next = status_r;
    slot_next   = slot_r;
    ctl         = '0;
    raddr       = issue_idx[IW-1:0];
    waddr       = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          op_next     = op_t'(kind);
          status_next = STAT_OK;
          slot_next   = '0;
          state_next  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        issue_next = '0;
        unique case (op)
          OP_INSERT: begin
            if (count == CAP_C) begin
              status_next = STAT_FULL;
            end else begin
              ctl.we     = 1'b1;
              waddr      = count[IW-1:0];
              slot_next  = count[IW-1:0];
              count_next = count + 1'b1;
            end
            state_next = ST_RESULT;
          end
          OP_REMOVE: begin
            if (count == '0) begin
              status_next = STAT_EMPTY;
              state_next  = ST_RESULT;
            end else begin
              state_next = ST_SCAN;
            end
          end
          OP_SEARCH: begin
            if (count == '0) begin
              status_next = STAT_MISSING;
              state_next  = ST_RESULT;
            end else begin
              state_next = ST_SCAN;
            end
          end
          OP_NONE: begin
            state_next = ST_RESULT;
          end
          default: state_next = ST_RESULT;
        endcase
      end
      ST_SCAN: begin
        // issue the next read while comparing the one that just came back
        if (issue_idx < count) begin
          rv_next     = 1'b1;
          rd_idx_next = issue_idx[IW-1:0];
          issue_next  = issue_idx + 1'b1;
        end
        if (rv) begin
          if (hit) begin
            slot_next = rd_idx;
            if (op == OP_SEARCH) begin
              ctl.load_found = 1'b1;
              state_next     = ST_RESULT;
            end else begin
              // drop any read in flight and restart just past the match
              rv_next    = 1'b0;
              issue_next = CW'(rd_idx) + 1'b1;
              state_next = ST_SHIFT;
            end
          end else if (CW'(rd_idx) == count - 1'b1) begin
            status_next = STAT_MISSING;
            state_next  = ST_RESULT;
          end
        end
      end
      ST_SHIFT: begin
        if (issue_idx < count) begin
          rv_next     = 1'b1;
          rd_idx_next = issue_idx[IW-1:0];
          issue_next  = issue_idx + 1'b1;
        end
        if (rv) begin
          ctl.we        = 1'b1;
          ctl.shift_src = 1'b1;
          waddr         = rd_idx - 1'b1;
        end else if (!(issue_idx < count)) begin
          count_next = count - 1'b1;
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        ctl.done   = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy       = (state != ST_IDLE);
  assign res_status = status_r;
  assign res_slot   = slot_r;

endmodule

### test/keyed_list_insert_remove_search_tb.sv
// testbench for keyed_list_insert_remove_search: a directed table of table operations
// followed by random insert, remove and search traffic, checked against a table model
// depends on klirs_pkg and the keyed_list_insert_remove_search top level
`timescale 1ns / 100ps

module keyed_list_insert_remove_search_tb import klirs_pkg::*;;

  localparam int TABLE_DEPTH = 16;
  localparam int POOL_SIZE   = 24;
  localparam int PHASE_ITEMS = 580;

  typedef struct packed {
    status_t     status;
    logic [3:0]  slot;
    logic [63:0] cls0;
    logic [63:0] cls1;
    logic [23:0] cls2;
    logic [31:0] amt;
    logic [4:0]  occ;
  } outcome_t;

  typedef struct {
    op_t          op;
    logic [231:0] name;
    logic [151:0] cls;
    logic [31:0]  amt;
    bit           fixed;
    outcome_t     want;
  } plan_row_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  kind;
  logic [63:0] key_word_0;
  logic [63:0] key_word_1;
  logic [63:0] key_word_2;
  logic [39:0] key_word_3;
  logic [63:0] class_word_0;
  logic [63:0] class_word_1;
  logic [23:0] class_word_2;
  logic signed [31:0] amount;
  logic        done;
  logic [1:0]  status;
  logic [3:0]  slot;
  logic [63:0] found_class_0;
  logic [63:0] found_class_1;
  logic [23:0] found_class_2;
  logic signed [31:0] found_amount;
  logic [4:0]  occupancy;

  // table model
  logic [231:0] name_tab[TABLE_DEPTH];
  logic [151:0] class_tab[TABLE_DEPTH];
  logic [31:0]  amount_tab[TABLE_DEPTH];
  int           held;

  outcome_t     pending_q[$];
  plan_row_t    directed_q[$];
  logic [231:0] name_pool[POOL_SIZE];
  outcome_t     head;
  int           mismatches;

  keyed_list_insert_remove_search i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .key_word_0    (key_word_0),
    .key_word_1    (key_word_1),
    .key_word_2    (key_word_2),
    .key_word_3    (key_word_3),
    .class_word_0  (class_word_0),
    .class_word_1  (class_word_1),
    .class_word_2  (class_word_2),
    .amount        (amount),
    .done          (done),
    .status        (status),
    .slot          (slot),
    .found_class_0 (found_class_0),
    .found_class_1 (found_class_1),
    .found_class_2 (found_class_2),
    .found_amount  (found_amount),
    .occupancy     (occupancy)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // a name ends at its first zero byte, everything after it reads as zero
  function automatic logic [231:0] trim_name(logic [231:0] raw);
    logic [231:0] t;
    bit ended;
    t = '0;
    ended = 1'b0;
    for (int b = 0; b < 29; b++) begin
      if (raw[8*b +: 8] == 8'd0) ended = 1'b1;
      if (!ended) t[8*b +: 8] = raw[8*b +: 8];
    end
    return t;
  endfunction

  function automatic logic [231:0] text_name(string s);
    logic [231:0] v;
    v = '0;
    for (int i = 0; i < s.len() && i < 29; i++) v[8*i +: 8] = s[i];
    return v;
  endfunction

  function automatic logic [231:0] random_name(int len);
    logic [231:0] v;
    v = '0;
    for (int b = 0; b < len; b++) v[8*b +: 8] = 8'($urandom_range(1, 255));
    return v;
  endfunction

  function automatic logic [255:0] random_bits();
    logic [255:0] v;
    for (int w = 0; w < 8; w++) v[32*w +: 32] = $urandom;
    return v;
  endfunction

  // fill the bytes past the terminator with garbage, same name after trimming
  function automatic logic [231:0] add_junk(logic [231:0] name);
    logic [231:0] v;
    int len;
    v = name;
    len = 29;
    for (int b = 28; b >= 0; b--) if (name[8*b +: 8] == 8'd0) len = b;
    for (int b = len + 1; b < 29; b++) v[8*b +: 8] = 8'($urandom);
    return v;
  endfunction

  function automatic outcome_t make_want(status_t st, int pos, logic [151:0] cls,
                                         logic [31:0] amt, int occ);
    outcome_t r;
    r.status = st;
    r.slot   = 4'(pos);
    r.cls0   = cls[63:0];
    r.cls1   = cls[127:64];
    r.cls2   = cls[151:128];
    r.amt    = amt;
    r.occ    = 5'(occ);
    return r;
  endfunction

  function automatic outcome_t apply_to_table(op_t op, logic [231:0] raw_key,
                                              logic [151:0] cls, logic [31:0] amt);
    outcome_t r;
    logic [231:0] name;
    int hit;
    r = '0;
    name = trim_name(raw_key);
    hit = -1;
    for (int i = 0; i < held; i++) if (hit < 0 && name_tab[i] == name) hit = i;
    unique case (op)
      OP_INSERT: begin
        if (held >= TABLE_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          name_tab[held]   = name;
          class_tab[held]  = cls;
          amount_tab[held] = amt;
          r.slot = 4'(held);
          held++;
        end
      end
      OP_REMOVE: begin
        if (held == 0) begin
          r.status = STAT_EMPTY;
        end else if (hit < 0) begin
          r.status = STAT_MISSING;
        end else begin
          for (int i = hit; i < held - 1; i++) begin
            name_tab[i]   = name_tab[i + 1];
            class_tab[i]  = class_tab[i + 1];
            amount_tab[i] = amount_tab[i + 1];
          end
          held--;
          r.slot = 4'(hit);
        end
      end
      OP_SEARCH: begin
        if (hit < 0) begin
          r.status = STAT_MISSING;
        end else begin
          r.slot = 4'(hit);
          r.cls0 = class_tab[hit][63:0];
          r.cls1 = class_tab[hit][127:64];
          r.cls2 = class_tab[hit][151:128];
          r.amt  = amount_tab[hit];
        end
      end
      default: ;
    endcase
    r.occ = 5'(held);
    return r;
  endfunction

  task automatic add_row(op_t op, logic [231:0] name, logic [151:0] cls,
                         logic [31:0] amt, bit fixed, outcome_t want);
    plan_row_t row;
    row.op    = op;
    row.name  = name;
    row.cls   = cls;
    row.amt   = amt;
    row.fixed = fixed;
    row.want  = want;
    directed_q.push_back(row);
  endtask

  // offer one item, hold it until taken, then record what it should produce
  task automatic issue(op_t op, logic [231:0] name, logic [151:0] cls, logic [31:0] amt,
                       bit fixed, outcome_t want, int idle_pct);
    outcome_t predicted;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    kind         <= op;
    key_word_0   <= name[63:0];
    key_word_1   <= name[127:64];
    key_word_2   <= name[191:128];
    key_word_3   <= name[231:192];
    class_word_0 <= cls[63:0];
    class_word_1 <= cls[127:64];
    class_word_2 <= cls[151:128];
    amount       <= amt;
    start        <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = apply_to_table(op, name, cls, amt);
    pending_q.push_back(fixed ? want : predicted);
  endtask

  task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        $error("result with no item pending");
        mismatches++;
      end else begin
        head = pending_q.pop_front();
        check_field("status", 64'(head.status), 64'(status));
        check_field("slot", 64'(head.slot), 64'(slot));
        check_field("found_class_0", head.cls0, found_class_0);
        check_field("found_class_1", head.cls1, found_class_1);
        check_field("found_class_2", 64'(head.cls2), 64'(found_class_2));
        check_field("found_amount", 64'(head.amt), 64'(unsigned'(found_amount)));
        check_field("occupancy", 64'(head.occ), 64'(occupancy));
      end
    end
  end

  initial begin
    logic [231:0] name_a;
    logic [231:0] name_b;
    logic [231:0] name_x;
    logic [231:0] name;
    logic [151:0] cls;
    logic [31:0]  amt;
    logic [255:0] bits;
    op_t          op;
    int           pick;
    int           idle_pct;
    outcome_t     none_want;

    rst = 1'b1;
    start = 1'b0;
    kind = '0;
    key_word_0 = '0;
    key_word_1 = '0;
    key_word_2 = '0;
    key_word_3 = '0;
    class_word_0 = '0;
    class_word_1 = '0;
    class_word_2 = '0;
    amount = '0;
    held = 0;
    mismatches = 0;
    none_want = '0;

    name_a = text_name("bolt");
    name_b = {29{8'hFF}};
    name_x = text_name("gear");
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i < 6) name_pool[i] = random_name(29);
      else if (i == 6) name_pool[i] = '0;
      else if (i == 7) name_pool[i] = random_name(1);
      else name_pool[i] = random_name($urandom_range(2, 28));
    end

    // empty table, extremes of amount and class, names with garbage past the end
    add_row(OP_SEARCH, name_a, '0, '0, 1, make_want(STAT_MISSING, 0, '0, '0, 0));
    add_row(OP_REMOVE, name_a, '0, '0, 1, make_want(STAT_EMPTY, 0, '0, '0, 0));
    add_row(OP_NONE, name_b, '1, '1, 1, make_want(STAT_OK, 0, '0, '0, 0));
    add_row(OP_INSERT, name_a, '1, 32'h7FFF_FFFF, 1, make_want(STAT_OK, 0, '0, '0, 1));
    add_row(OP_INSERT, name_b, '0, 32'h8000_0000, 1, make_want(STAT_OK, 1, '0, '0, 2));
    add_row(OP_INSERT, '0, random_bits(), '0, 1, make_want(STAT_OK, 2, '0, '0, 3));
    add_row(OP_SEARCH, add_junk(name_a), '0, '0, 1,
            make_want(STAT_OK, 0, '1, 32'h7FFF_FFFF, 3));
    add_row(OP_SEARCH, name_b, '0, '0, 0, none_want);
    add_row(OP_SEARCH, add_junk('0), '0, '0, 0, none_want);
    add_row(OP_INSERT, add_junk(name_a), random_bits(), 32'hFFFF_FFFF, 0, none_want);
    add_row(OP_SEARCH, name_a, '0, '0, 0, none_want);
    add_row(OP_NONE, add_junk(name_a), random_bits(), $urandom, 0, none_want);
    add_row(OP_SEARCH, name_x, '0, '0, 1, make_want(STAT_MISSING, 0, '0, '0, 4));
    add_row(OP_REMOVE, name_x, '0, '0, 1, make_want(STAT_MISSING, 0, '0, '0, 4));
    add_row(OP_REMOVE, name_a, '0, '0, 0, none_want);
    add_row(OP_SEARCH, name_a, '0, '0, 0, none_want);
    add_row(OP_REMOVE, name_b, '0, '0, 0, none_want);
    add_row(OP_REMOVE, '0, '0, '0, 0, none_want);
    add_row(OP_REMOVE, name_a, '0, '0, 0, none_want);
    add_row(OP_REMOVE, name_a, '0, '0, 1, make_want(STAT_EMPTY, 0, '0, '0, 0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_q[i])
      issue(directed_q[i].op, directed_q[i].name, directed_q[i].cls, directed_q[i].amt,
            directed_q[i].fixed, directed_q[i].want, 0);

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 0 : (phase == 1) ? 68 : 14;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // alternate fill-heavy and drain-heavy stretches so full and empty both occur
        pick = $urandom_range(99);
        if ((n / 60) % 2 == 0)
          op = (pick < 55) ? OP_INSERT : (pick < 70) ? OP_REMOVE :
               (pick < 95) ? OP_SEARCH : OP_NONE;
        else
          op = (pick < 15) ? OP_INSERT : (pick < 65) ? OP_REMOVE :
               (pick < 95) ? OP_SEARCH : OP_NONE;
        bits = random_bits();
        if ($urandom_range(9) == 0) begin
          name = bits[231:0];
        end else begin
          name = name_pool[$urandom_range(POOL_SIZE - 1)];
          if ($urandom_range(2) == 0) name = add_junk(name);
        end
        pick = $urandom_range(9);
        cls = (pick == 0) ? '0 : (pick == 1) ? '1 : random_bits();
        pick = $urandom_range(9);
        amt = (pick == 0) ? 32'h8000_0000 : (pick == 1) ? 32'h7FFF_FFFF : $urandom;
        issue(op, name, cls, amt, 0, none_want, idle_pct);
      end
      // let the pending results drain before the next idling pattern
      start <= 1'b0;
      while (pending_q.size() != 0) @(posedge clk);
    end

    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
